FILE: hdl/bopf_pkg.sv
// bopf_pkg: shared types, constants and helpers for the box overlap pair filter
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package bopf_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned TypeW    = 3;
  localparam int unsigned StripW   = 10;
  localparam int unsigned PosW     = 12;
  localparam int unsigned IndexW   = 16;
  localparam int unsigned RatioW   = 17;
  localparam int unsigned AreaW    = 2 * CoordW;
  localparam int unsigned UnionW   = AreaW + 1;
  localparam int unsigned MaxBlocks = 65536;

  localparam logic [CoordW-1:0] SignBit  = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic [RatioW-1:0] OneQ16   = {1'b1, {(RatioW-1){1'b0}}};

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } bopf_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_UNION_A,
    ST_UNION_B,
    ST_FIN_GO,
    ST_FIN_WAIT,
    ST_DONE
  } bopf_state_e;

  typedef struct packed {
    logic                     command;
    logic signed [CoordW-1:0] box_min_x;
    logic signed [CoordW-1:0] box_max_x;
    logic signed [CoordW-1:0] box_min_y;
    logic signed [CoordW-1:0] box_max_y;
    logic [TypeW-1:0]         source_type;
    logic [StripW-1:0]        strip_number;
    logic [PosW-1:0]          strip_position;
    logic [IndexW-1:0]        block_index;
  } bopf_in_t;

  typedef struct packed {
    logic [RatioW-1:0] overlap_ratio;
    logic              adj_flag;
    logic              accepted;
    logic [IndexW-1:0] candidate_index;
  } bopf_out_t;

  // offset binary: signed coordinates then order as unsigned
  function automatic logic [CoordW-1:0] bopf_bias(input logic [CoordW-1:0] v);
    return v ^ SignBit;
  endfunction

  // width of an interval, clamped at zero when inverted
  function automatic logic [CoordW-1:0] bopf_extent(input logic [CoordW-1:0] lo,
                                                    input logic [CoordW-1:0] hi);
    return (hi > lo) ? (hi - lo) : '0;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/bopf_serial_mul.sv
// bopf_serial_mul: unsigned shift-add multiplier, one multiplier bit per cycle
// depends on bopf_pkg (import only for house consistency of widths)
`timescale 1ns / 1ps
`default_nettype none

module bopf_serial_mul import bopf_pkg::*; #(
  parameter int unsigned AW = CoordW,
  parameter int unsigned BW = CoordW
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [AW-1:0]     a_i,
  input  wire logic [BW-1:0]     b_i,
  output logic                   busy_o,
  output logic [AW+BW-1:0]       prod_o
);

  localparam int unsigned CntW = $clog2(BW + 1);

  logic              busy_q, busy_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]     mcand_q, mcand_d;
  logic [AW+BW-1:0]  prod_q, prod_d;
  logic [AW:0]       sum;

  // add the multiplicand into the upper half when the low bit is set, then shift right
  assign sum = {1'b0, prod_q[AW+BW-1 -: AW]} + (prod_q[0] ? {1'b0, mcand_q} : '0);

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    mcand_d = mcand_q;
    prod_d  = prod_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = CntW'(BW);
      mcand_d = a_i;
      prod_d  = {{AW{1'b0}}, b_i};
    end else if (busy_q) begin
      prod_d = {sum, prod_q[BW-1:1]};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    prod_q  <= prod_d;
  end

  assign busy_o = busy_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

FILE: hdl/bopf_div.sv
// bopf_div: restoring divider, one quotient bit per cycle, msb first
// depends on bopf_pkg for default widths
`timescale 1ns / 1ps
`default_nettype none

module bopf_div import bopf_pkg::*; #(
  parameter int unsigned NW = AreaW,
  parameter int unsigned DW = UnionW,
  parameter int unsigned QW = RatioW
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               busy_o,
  output logic [QW-1:0]      quot_o
);

  localparam int unsigned CntW = $clog2(QW + 1);

  logic            busy_q, busy_d;
  logic            first_q, first_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DW:0]     rem_q, rem_d;
  logic [DW-1:0]   den_q, den_d;
  logic [QW-1:0]   quot_q, quot_d;
  logic [DW:0]     trial;
  logic            fits;

  // the first step compares the plain numerator, later ones the doubled remainder
  assign trial = first_q ? rem_q : {rem_q[DW-1:0], 1'b0};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d  = busy_q;
    first_d = first_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quot_d  = quot_q;
    if (start_i) begin
      busy_d  = 1'b1;
      first_d = 1'b1;
      cnt_d   = CntW'(QW);
      rem_d   = (DW+1)'(num_i);
      den_d   = den_i;
      quot_d  = '0;
    end else if (busy_q) begin
      first_d = 1'b0;
      rem_d   = fits ? (trial - {1'b0, den_q}) : trial;
      quot_d  = {quot_q[QW-2:0], fits};
      cnt_d   = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    quot_q  <= quot_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

FILE: hdl/box_overlap_pair_filter.sv
// box_overlap_pair_filter: intersection over union of a reference and a candidate box
// depends on bopf_pkg, bopf_serial_mul, bopf_div
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | input     | in_valid_i / in_ready_o   | bopf_in_t  in_data_i
//   out     | output    | out_valid_o / out_ready_i | bopf_out_t out_data_o
//   cfg     | input     | cfg_valid_i / cfg_ready_o | min_overlap, 17 bits
//
// a load item gives no result; a test item occupies the block through the 32-step
// shift-add area multipliers and the 17-step divider running alongside the threshold
// multiplier, and the divide is skipped when the union is zero.
// reset clears the reference block to all zero and min_overlap to zero.
// the finished result sits in an output register, so the next item is taken while
// it waits; a test item only stalls at its end if the previous result is still held.
`timescale 1ns / 1ps
`default_nettype none

module box_overlap_pair_filter import bopf_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire bopf_in_t      in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output bopf_out_t          out_data_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [RatioW-1:0] cfg_data_i
);

  bopf_state_e state_q, state_d;

  // reference block
  logic [CoordW-1:0] ref_box_q [4];
  logic [TypeW-1:0]  ref_type_q;
  logic [StripW-1:0] ref_strip_q;
  logic [PosW-1:0]   ref_pos_q;
  logic [IndexW-1:0] ref_idx_q;
  logic [RatioW-1:0] min_overlap_q;

  // candidate and working registers
  logic [CoordW-1:0] cand_box_q [4];
  logic [TypeW-1:0]  cand_type_q;
  logic [StripW-1:0] cand_strip_q;
  logic [PosW-1:0]   cand_pos_q;
  logic [IndexW-1:0] cand_idx_q;
  logic [CoordW-1:0] isect_q [4];
  logic [CoordW-1:0] ref_b [4];
  logic              adj_q;
  logic              idx_ok_q;
  logic [AreaW-1:0]  diff_q;
  logic [UnionW-1:0] uni_q;
  logic              uni_nz_q;

  logic              out_valid_q;
  bopf_out_t         out_q;

  logic in_xfer, load_xfer, test_xfer;
  logic mul_start, fin_start, out_load;

  logic                     mul_r_busy, mul_c_busy, mul_i_busy, thr_busy, div_busy;
  logic [AreaW-1:0]         area_r, area_c, area_i;
  logic [UnionW+RatioW-1:0] thr_prod;
  logic [RatioW-1:0]        quot;
  logic [UnionW+RatioW-1:0] lhs;
  logic [PosW:0]            cand_pos_p1, ref_pos_p1;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign load_xfer   = in_xfer && (in_data_i.command == CMD_LOAD);
  assign test_xfer   = in_xfer && (in_data_i.command == CMD_TEST);

  for (genvar k = 0; k < 4; k++) begin : g_ref_bias
    assign ref_b[k] = bopf_bias(ref_box_q[k]);
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    fin_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (test_xfer) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = ST_MUL_GO;
      end
      ST_MUL_GO: begin
        mul_start = 1'b1;
        state_d   = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (!mul_r_busy && !mul_c_busy && !mul_i_busy) begin
          state_d = ST_UNION_A;
        end
      end
      ST_UNION_A: begin
        state_d = ST_UNION_B;
      end
      ST_UNION_B: begin
        state_d = ST_FIN_GO;
      end
      ST_FIN_GO: begin
        // zero union skips the divide, the result is forced to zero
        if (uni_q != '0) begin
          fin_start = 1'b1;
          state_d   = ST_FIN_WAIT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_FIN_WAIT: begin
        if (!thr_busy && !div_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- config and reference
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_overlap_q <= '0;
      for (int k = 0; k < 4; k++) begin
        ref_box_q[k] <= '0;
      end
      ref_type_q  <= '0;
      ref_strip_q <= '0;
      ref_pos_q   <= '0;
      ref_idx_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        min_overlap_q <= cfg_data_i;
      end
      if (load_xfer) begin
        ref_box_q[0] <= in_data_i.box_min_x;
        ref_box_q[1] <= in_data_i.box_max_x;
        ref_box_q[2] <= in_data_i.box_min_y;
        ref_box_q[3] <= in_data_i.box_max_y;
        ref_type_q   <= in_data_i.source_type;
        ref_strip_q  <= in_data_i.strip_number;
        ref_pos_q    <= in_data_i.strip_position;
        ref_idx_q    <= in_data_i.block_index;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  assign cand_pos_p1 = {1'b0, cand_pos_q} + (PosW+1)'(1);
  assign ref_pos_p1  = {1'b0, ref_pos_q} + (PosW+1)'(1);

  always_ff @(posedge clk_i) begin
    if (test_xfer) begin
      cand_box_q[0] <= bopf_bias(in_data_i.box_min_x);
      cand_box_q[1] <= bopf_bias(in_data_i.box_max_x);
      cand_box_q[2] <= bopf_bias(in_data_i.box_min_y);
      cand_box_q[3] <= bopf_bias(in_data_i.box_max_y);
      cand_type_q   <= in_data_i.source_type;
      cand_strip_q  <= in_data_i.strip_number;
      cand_pos_q    <= in_data_i.strip_position;
      cand_idx_q    <= in_data_i.block_index;
    end
    if (state_q == ST_PREP) begin
      isect_q[0] <= (ref_b[0] > cand_box_q[0]) ? ref_b[0] : cand_box_q[0];
      isect_q[1] <= (ref_b[1] < cand_box_q[1]) ? ref_b[1] : cand_box_q[1];
      isect_q[2] <= (ref_b[2] > cand_box_q[2]) ? ref_b[2] : cand_box_q[2];
      isect_q[3] <= (ref_b[3] < cand_box_q[3]) ? ref_b[3] : cand_box_q[3];
      adj_q <= (cand_type_q == ref_type_q) && (cand_strip_q == ref_strip_q) &&
               ((cand_pos_p1 == {1'b0, ref_pos_q}) || (ref_pos_p1 == {1'b0, cand_pos_q}));
      idx_ok_q <= (cand_idx_q > ref_idx_q) &&
                  (32'(cand_idx_q) < MaxBlocks) && (32'(ref_idx_q) < MaxBlocks);
    end
    if (state_q == ST_UNION_A) begin
      // the intersection never exceeds the reference area
      diff_q <= area_r - area_i;
    end
    if (state_q == ST_UNION_B) begin
      uni_q <= {1'b0, diff_q} + {1'b0, area_c};
    end
    if (state_q == ST_FIN_GO) begin
      uni_nz_q <= (uni_q != '0);
    end
  end

  bopf_serial_mul #(.AW(CoordW), .BW(CoordW)) u_mul_ref (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (bopf_extent(ref_b[0], ref_b[1])),
    .b_i     (bopf_extent(ref_b[2], ref_b[3])),
    .busy_o  (mul_r_busy),
    .prod_o  (area_r)
  );

  bopf_serial_mul #(.AW(CoordW), .BW(CoordW)) u_mul_cand (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (bopf_extent(cand_box_q[0], cand_box_q[1])),
    .b_i     (bopf_extent(cand_box_q[2], cand_box_q[3])),
    .busy_o  (mul_c_busy),
    .prod_o  (area_c)
  );

  bopf_serial_mul #(.AW(CoordW), .BW(CoordW)) u_mul_isect (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (bopf_extent(isect_q[0], isect_q[1])),
    .b_i     (bopf_extent(isect_q[2], isect_q[3])),
    .busy_o  (mul_i_busy),
    .prod_o  (area_i)
  );

  // threshold side of the exact compare: union * min_overlap
  bopf_serial_mul #(.AW(UnionW), .BW(RatioW)) u_mul_thr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fin_start),
    .a_i     (uni_q),
    .b_i     (min_overlap_q),
    .busy_o  (thr_busy),
    .prod_o  (thr_prod)
  );

  bopf_div #(.NW(AreaW), .DW(UnionW), .QW(RatioW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fin_start),
    .num_i   (area_i),
    .den_i   (uni_q),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  // intersection scaled by one in Q1.16
  assign lhs = (UnionW+RatioW)'({area_i, {(RatioW-1){1'b0}}});

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.overlap_ratio   <= uni_nz_q ? quot : '0;
      out_q.adj_flag        <= adj_q;
      out_q.accepted        <= uni_nz_q && (thr_prod < lhs) && idx_ok_q && !adj_q;
      out_q.candidate_index <= cand_idx_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: hdl/bopf_checker.sv
// bopf_checker: port-level checks on the box overlap pair filter
// depends on bopf_pkg; bound to box_overlap_pair_filter at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module bopf_checker import bopf_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire bopf_out_t out_data_i
);

  // a result that is not taken stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  a_acc_not_adj: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_data_i.accepted && out_data_i.adj_flag))
    else $error("adjacent pair accepted");

  // intersection never exceeds the union
  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.overlap_ratio <= OneQ16))
    else $error("overlap ratio above one");

  // candidate index must exceed the reference index, so it cannot be zero
  a_acc_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.accepted |-> (out_data_i.candidate_index != '0))
    else $error("accepted pair with candidate index zero");

endmodule

bind box_overlap_pair_filter bopf_checker u_bopf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire

FILE: tb/sv/tb_box_overlap_pair_filter.sv
// tb_box_overlap_pair_filter: self-checking testbench for the box overlap pair filter
// depends on bopf_pkg and box_overlap_pair_filter; predicts IoU, adjacency and accept per test
`timescale 1ns / 1ps

module tb_box_overlap_pair_filter;
  import bopf_pkg::*;

  localparam int unsigned SettleCycles = 70;    // covers a load still in flight
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned RandomPhases = 6;
  localparam int unsigned PhaseItems   = 119;
  localparam int unsigned BurstItems   = 12;

  localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;
  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7fff_ffff;

  typedef enum logic {
    ROW_ITEM,
    ROW_THRESHOLD
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [RatioW-1:0] thr;
    bopf_in_t          blk;
    logic              typed;
    bopf_out_t         want;
  } dir_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  bopf_in_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  bopf_out_t         out_data_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [RatioW-1:0] cfg_data_i  = '0;

  // predictor state
  bopf_in_t          ref_blk     = '0;
  logic [RatioW-1:0] min_overlap = '0;

  bopf_out_t   pending_overlaps[$];
  dir_row_t    dir_rows[$];

  int unsigned fail_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned loads_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned accepts_seen  = 0;
  int unsigned cfg_writes    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned box_scale     = 0;
  bit          tx_steady     = 1'b0;
  bit          rx_steady     = 1'b0;
  bit          long_hold     = 1'b0;

  box_overlap_pair_filter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- prediction

  function automatic logic [CoordW-1:0] span(input logic signed [CoordW-1:0] lo,
                                              input logic signed [CoordW-1:0] hi);
    return (hi > lo) ? hi - lo : '0;
  endfunction

  function automatic bopf_out_t predict_overlap(input bopf_in_t cand);
    logic signed [CoordW-1:0] rx0, rx1, ry0, ry1, cx0, cx1, cy0, cy1;
    logic signed [CoordW-1:0] ix0, ix1, iy0, iy1;
    logic [AreaW-1:0] area_ref, area_cand, inter;
    logic [127:0]     union_sum, scaled_inter;
    logic [PosW:0]    cpos, rpos;
    logic             adjacent;
    bopf_out_t        r;
    rx0 = ref_blk.box_min_x;
    rx1 = ref_blk.box_max_x;
    ry0 = ref_blk.box_min_y;
    ry1 = ref_blk.box_max_y;
    cx0 = cand.box_min_x;
    cx1 = cand.box_max_x;
    cy0 = cand.box_min_y;
    cy1 = cand.box_max_y;
    ix0 = (rx0 > cx0) ? rx0 : cx0;
    ix1 = (rx1 < cx1) ? rx1 : cx1;
    iy0 = (ry0 > cy0) ? ry0 : cy0;
    iy1 = (ry1 < cy1) ? ry1 : cy1;
    area_ref  = {32'd0, span(rx0, rx1)} * {32'd0, span(ry0, ry1)};
    area_cand = {32'd0, span(cx0, cx1)} * {32'd0, span(cy0, cy1)};
    inter     = {32'd0, span(ix0, ix1)} * {32'd0, span(iy0, iy1)};
    // intersection never exceeds the reference area
    union_sum    = {64'd0, area_ref - inter} + {64'd0, area_cand};
    scaled_inter = {48'd0, inter, 16'd0};
    cpos = {1'b0, cand.strip_position};
    rpos = {1'b0, ref_blk.strip_position};
    adjacent = (cand.source_type == ref_blk.source_type) &&
               (cand.strip_number == ref_blk.strip_number) &&
               ((cpos + 1'b1 == rpos) || (rpos + 1'b1 == cpos));
    r.adj_flag        = adjacent;
    r.candidate_index = cand.block_index;
    if (union_sum == '0) begin
      r.overlap_ratio = '0;
      r.accepted      = 1'b0;
    end else begin
      r.overlap_ratio = 17'(scaled_inter / union_sum);
      r.accepted = (scaled_inter > union_sum * 128'(min_overlap)) &&
                   (cand.block_index > ref_blk.block_index) && !adjacent &&
                   (cand.block_index < MaxBlocks) && (ref_blk.block_index < MaxBlocks);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [CoordW-1:0] corner_value();
    case ($urandom_range(0, 3))
      0:       return CoordMin;
      1:       return CoordMax;
      2:       return '0;
      default: return -1;
    endcase
  endfunction

  function automatic bopf_in_t blk_of(input bopf_cmd_e cmd,
                                      input logic signed [CoordW-1:0] x0, x1, y0, y1,
                                      input int unsigned typ, strip, pos, idx);
    bopf_in_t b;
    b.command        = cmd;
    b.box_min_x      = x0;
    b.box_max_x      = x1;
    b.box_min_y      = y0;
    b.box_max_y      = y1;
    b.source_type    = 3'(typ);
    b.strip_number   = 10'(strip);
    b.strip_position = 12'(pos);
    b.block_index    = 16'(idx);
    return b;
  endfunction

  function automatic bopf_out_t res_of(input int unsigned ratio, adj, acc, idx);
    bopf_out_t r;
    r.overlap_ratio   = 17'(ratio);
    r.adj_flag        = adj[0];
    r.accepted        = acc[0];
    r.candidate_index = 16'(idx);
    return r;
  endfunction

  function automatic void add_row(input row_kind_e kind, input logic [RatioW-1:0] thr,
                                  input bopf_in_t blk, input logic typed,
                                  input bopf_out_t want);
    dir_row_t row;
    row.kind  = kind;
    row.thr   = thr;
    row.blk   = blk;
    row.typed = typed;
    row.want  = want;
    dir_rows = {dir_rows, row};
  endfunction

  // boxes mostly land in a shared scaled window so overlaps are partial and varied
  function automatic bopf_in_t random_item();
    bopf_in_t b;
    int unsigned pick;
    logic signed [CoordW-1:0] lo_x, lo_y, w_x, w_y;
    b = '0;
    b.command = ($urandom_range(0, 4) == 0) ? CMD_LOAD : CMD_TEST;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      b.box_min_x = $urandom;
      b.box_max_x = $urandom;
      b.box_min_y = $urandom;
      b.box_max_y = $urandom;
    end else if (pick == 1) begin
      b.box_min_x = corner_value();
      b.box_max_x = corner_value();
      b.box_min_y = corner_value();
      b.box_max_y = corner_value();
    end else begin
      lo_x = $signed($urandom_range(0, 128)) - 64;
      lo_y = $signed($urandom_range(0, 128)) - 64;
      w_x  = $urandom_range(0, 128);
      w_y  = $urandom_range(0, 128);
      if (pick == 2) w_x = -w_x - 1;  // inverted x extent
      b.box_min_x = lo_x <<< box_scale;
      b.box_max_x = (lo_x + w_x) <<< box_scale;
      b.box_min_y = lo_y <<< box_scale;
      b.box_max_y = (lo_y + w_y) <<< box_scale;
    end
    if (b.command == CMD_LOAD) begin
      b.source_type    = 3'($urandom);
      b.strip_number   = 10'($urandom);
      b.strip_position = 12'($urandom);
      b.block_index    = $urandom_range(0, 1) ? 16'($urandom_range(0, 2000)) : 16'($urandom);
    end else begin
      b.source_type  = ($urandom_range(0, 3) != 0) ? ref_blk.source_type : 3'($urandom);
      b.strip_number = ($urandom_range(0, 3) != 0) ? ref_blk.strip_number : 10'($urandom);
      case ($urandom_range(0, 5))
        0:       b.strip_position = ref_blk.strip_position + 1'b1;
        1:       b.strip_position = ref_blk.strip_position - 1'b1;
        2:       b.strip_position = ref_blk.strip_position;
        default: b.strip_position = 12'($urandom);
      endcase
      b.block_index = 16'($urandom);
    end
    return b;
  endfunction

  // ---------------------------------------------------------------- channel tasks

  task automatic send_item(input bopf_in_t blk, input logic typed, input bopf_out_t want);
    bopf_out_t exp_res;
    in_valid_i <= 1'b1;
    in_data_i  <= blk;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (blk.command == CMD_LOAD) begin
      ref_blk = blk;
      loads_sent++;
    end else begin
      exp_res = typed ? want : predict_overlap(blk);
      pending_overlaps = {pending_overlaps, exp_res};
    end
  endtask

  task automatic sender_gap();
    int unsigned n;
    n = idle_len();
    if (!tx_steady && n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // sender stops and waits for every outstanding result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_overlaps.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [RatioW-1:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    min_overlap = v;
    cfg_writes++;
  endtask

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    fail_count++;
    $display("%0t: %s expected %0d got %0d", $time, what, want, got);
  endtask

  task automatic check_result(input bopf_out_t got);
    bopf_out_t want;
    results_seen++;
    if (got.accepted) accepts_seen++;
    if (pending_overlaps.size() == 0) begin
      report_mismatch("unrequested result, candidate_index", 0, got.candidate_index);
    end else begin
      want = pending_overlaps.pop_front();
      if (got.overlap_ratio !== want.overlap_ratio)
        report_mismatch("overlap_ratio", want.overlap_ratio, got.overlap_ratio);
      if (got.adj_flag !== want.adj_flag)
        report_mismatch("adj_flag", want.adj_flag, got.adj_flag);
      if (got.accepted !== want.accepted)
        report_mismatch("accepted", want.accepted, got.accepted);
      if (got.candidate_index !== want.candidate_index)
        report_mismatch("candidate_index", want.candidate_index, got.candidate_index);
    end
  endtask

  // ---------------------------------------------------------------- result side

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result(out_data_o);
  end

  initial begin : receiver
    int unsigned n;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (rx_steady) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        n = idle_len();
        if (n > 0) begin
          out_ready_i <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == StallLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, StallLimit, pending_overlaps.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    logic [RatioW-1:0] thr;
    bopf_in_t          blk;

    // reset reference first, then a known box and identity
    add_row(ROW_THRESHOLD, 17'd0, '0, 1'b0, '0);
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, 0, 10, 0, 10, 0, 0, 1, 5), 1'b1,
            res_of(0, 1, 0, 5));
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, 5, 5, 5, 5, 0, 0, 0, 0), 1'b1,
            res_of(0, 0, 0, 0));
    add_row(ROW_ITEM, '0, blk_of(CMD_LOAD, 0, 100, 0, 100, 2, 7, 10, 100), 1'b0, '0);
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, 0, 100, 0, 100, 2, 7, 50, 200), 1'b1,
            res_of(65536, 0, 1, 200));
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, 0, 100, 0, 100, 2, 7, 50, 50), 1'b1,
            res_of(65536, 0, 0, 50));
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, 0, 100, 0, 100, 2, 7, 50, 100), 1'b1,
            res_of(65536, 0, 0, 100));
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, 0, 100, 0, 100, 2, 7, 11, 300), 1'b1,
            res_of(65536, 1, 0, 300));
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, 0, 100, 0, 100, 2, 7, 9, 300), 1'b1,
            res_of(65536, 1, 0, 300));
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, 0, 100, 0, 100, 2, 7, 12, 300), 1'b1,
            res_of(65536, 0, 1, 300));
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, 0, 100, 0, 100, 3, 7, 11, 301), 1'b1,
            res_of(65536, 0, 1, 301));
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, 200, 300, 200, 300, 2, 7, 50, 400), 1'b1,
            res_of(0, 0, 0, 400));
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, 100, 0, 100, 0, 2, 7, 50, 401), 1'b1,
            res_of(0, 0, 0, 401));
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, 0, 100, 0, 50, 2, 7, 50, 402), 1'b1,
            res_of(32768, 0, 1, 402));
    // threshold exactly at the ratio must not accept
    add_row(ROW_THRESHOLD, 17'd32768, '0, 1'b0, '0);
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, 0, 100, 0, 50, 2, 7, 50, 403), 1'b1,
            res_of(32768, 0, 0, 403));
    add_row(ROW_THRESHOLD, 17'd32767, '0, 1'b0, '0);
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, 0, 100, 0, 50, 2, 7, 50, 404), 1'b1,
            res_of(32768, 0, 1, 404));
    add_row(ROW_THRESHOLD, 17'd65536, '0, 1'b0, '0);
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, 0, 100, 0, 100, 2, 7, 50, 405), 1'b1,
            res_of(65536, 0, 0, 405));
    add_row(ROW_THRESHOLD, 17'd0, '0, 1'b0, '0);
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, CoordMin, CoordMax, CoordMin, CoordMax,
            7, 1023, 4095, 65535), 1'b0, '0);
    add_row(ROW_ITEM, '0, blk_of(CMD_LOAD, CoordMin, CoordMax, CoordMin, CoordMax,
            7, 1023, 4095, 65535), 1'b0, '0);
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, CoordMin, CoordMax, CoordMin, CoordMax,
            7, 1023, 4094, 65535), 1'b1, res_of(65536, 1, 0, 65535));
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, CoordMax, CoordMin, CoordMax, CoordMin,
            5, 512, 2048, 65535), 1'b0, '0);
    // positions 0 and 4095 sit at opposite ends, no wrap
    add_row(ROW_ITEM, '0, blk_of(CMD_LOAD, -50, 50, -50, 50, 0, 0, 0, 0), 1'b0, '0);
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, -50, 50, -50, 50, 0, 0, 4095, 1), 1'b1,
            res_of(65536, 0, 1, 1));
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, -100, 0, -50, 50, 0, 0, 1, 2), 1'b0, '0);
    add_row(ROW_ITEM, '0, blk_of(CMD_TEST, CoordMin, CoordMax, CoordMin, CoordMax,
            6, 1, 3, 65535), 1'b0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_THRESHOLD) begin
        set_threshold(dir_rows[k].thr);
      end else begin
        send_item(dir_rows[k].blk, dir_rows[k].typed, dir_rows[k].want);
        sender_gap();
      end
    end

    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0:       thr = 17'($urandom_range(0, 65536));
        1:       thr = 17'd0;
        2:       thr = 17'd65536;
        3:       thr = 17'd1;
        4:       thr = 17'd65535;
        default: thr = 17'($urandom_range(16384, 49152));
      endcase
      set_threshold(thr);
      box_scale = (p % 2 == 0) ? $urandom_range(0, 22) : 0;
      tx_steady = (p == 3);
      rx_steady = (p == 3);
      if (p == 1) begin
        // receiver stalls while the sender keeps offering, so the input backs up
        long_hold = 1'b1;
        repeat (BurstItems) begin
          blk = random_item();
          blk.command = CMD_TEST;
          send_item(blk, 1'b0, '0);
        end
      end
      for (int i = 0; i < PhaseItems; i++) begin
        send_item(random_item(), 1'b0, '0);
        sender_gap();
      end
    end

    drain();
    $display("sent %0d blocks (%0d reference loads) across %0d threshold writes",
             items_sent, loads_sent, cfg_writes);
    $display("checked %0d overlap results, %0d flagged as accepted pairs",
             results_seen, accepts_seen);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
